// ----- hdl/esa_ct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esa_ct_pkg
// shared types and codes for the enhanced suffix array child table builder
// ----------------------------------------------------------------------------
package esa_ct_pkg;

   localparam int IDX_W   = 10;          // index field width
   localparam int LEN_W   = IDX_W + 1;   // lengths and stack counts up to 1024
   localparam int CHILD_W = IDX_W + 1;   // valid flag plus index

   // request operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BUILT = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } child_entry_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_READ  = 9'b000000010,
      ST_CLEAR = 9'b000000100,
      ST_LOAD  = 9'b000001000,
      ST_LCMP  = 9'b000010000,
      ST_TEST  = 9'b000100000,
      ST_POPW  = 9'b001000000,
      ST_CHK   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      PH_NEXT   = 2'd0,
      PH_UPDOWN = 2'd1,
      PH_FLUSH  = 2'd2
   } phase_type;

endpackage

// ----- hdl/esa_ct_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esa_ct_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module esa_ct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/esa_child_table_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esa_child_table_builder
// builds the compact child table of an enhanced suffix array from lcp values
// ----------------------------------------------------------------------------
// a plain lcp write answers straight from idle, a table read passes through the read
// state first; a build (write with last) clears table entries 0 to n-1, then runs each
//   of the two stack passes over the entries through the load, compare and test states,
//   with a pop wait state per pop in the first pass and pop wait and check states per pop
//   in the second pass and the flush (at most n pops in the first pass, at most n in the
//   second pass and flush together)
// one transaction at a time; the next request waits for the current response
// synchronous reset clears control, stack count and array length; no ram
//   clearing pass after reset, each build clears table entries 0 to n-1
module esa_child_table_builder #(
   parameter int MAX_LEN  = 1024,
   parameter int LCP_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [9:0]  req_index,
   input  logic [15:0] req_lcp_value,
   input  logic        req_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_child_value,
   output logic        rsp_child_valid,
   output logic [1:0]  rsp_status
);

   import esa_ct_pkg::*;

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SW = IDX_W + LCP_BITS;          // stack entry: index and lcp
   localparam logic [31:0] MAX_LEN_U = 32'(MAX_LEN);

   // control registers
   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [LEN_W-1:0]     len_ff, len_in;          // array length n
   logic [LEN_W-1:0]     sp_ff, sp_in;            // stacked entry count
   logic [LEN_W-1:0]     i_ff, i_in;              // scan position
   logic                 popped_ff, popped_in;
   logic                 rsp_valid_ff;

   // datapath registers; top of stack lives here, the rest in stack ram
   logic [IDX_W-1:0]     top_idx_ff, top_idx_in;
   logic [LCP_BITS-1:0]  top_lcp_ff, top_lcp_in;
   logic [IDX_W-1:0]     last_idx_ff, last_idx_in;
   logic [LCP_BITS-1:0]  last_lcp_ff, last_lcp_in;
   logic [LCP_BITS-1:0]  li_ff, li_in;
   logic [IDX_W-1:0]     rsp_value_ff;
   logic                 rsp_cvalid_ff;
   logic [1:0]           rsp_status_ff;

   // response load
   logic                 rsp_load;
   logic [IDX_W-1:0]     rsp_value_in;
   logic                 rsp_cvalid_in;
   logic [1:0]           rsp_status_in;

   // ram ports
   logic                 lcp_wr_en;
   logic [LCP_BITS-1:0]  lcp_rd;
   logic                 child_wr_en;
   logic [IDX_W-1:0]     child_wr_idx;
   child_entry_type      child_wr_data;
   logic [IDX_W-1:0]     child_rd_idx;
   child_entry_type      child_rd;
   logic                 stack_wr_en;
   logic [SW-1:0]        stack_rd;
   logic [IDX_W-1:0]     stack_rd_idx;
   logic [LCP_BITS-1:0]  stack_rd_lcp;

   logic                 req_take;
   logic                 wr_in_range;
   logic                 rd_in_range;
   logic [LEN_W-1:0]     i_prev;
   logic [LEN_W-1:0]     sp_below;

   assign req_stall   = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_take    = req_valid && !req_stall;
   assign wr_in_range = (32'(req_index) < MAX_LEN_U);
   assign rd_in_range = (len_ff >= LEN_W'(2)) && (LEN_W'(req_index) < (len_ff - LEN_W'(1)));
   assign i_prev      = i_ff - LEN_W'(1);
   assign sp_below    = sp_ff - LEN_W'(2);

   assign stack_rd_idx = stack_rd[SW-1 -: IDX_W];
   assign stack_rd_lcp = stack_rd[LCP_BITS-1:0];

   // table reads come from the popped entry in the pop wait state, from the request otherwise
   assign child_rd_idx = (state_ff == ST_POPW) ? stack_rd_idx : req_index;

   // memories
   esa_ct_ram #(.WIDTH(LCP_BITS), .DEPTH(MAX_LEN)) u_lcp_ram (
      .clock   (clock),
      .wr_en   (lcp_wr_en),
      .wr_addr (AW'(req_index)),
      .wr_data (LCP_BITS'(req_lcp_value)),
      .rd_addr (AW'(i_ff)),
      .rd_data (lcp_rd)
   );

   esa_ct_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_LEN)) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (AW'(child_wr_idx)),
      .wr_data (child_wr_data),
      .rd_addr (AW'(child_rd_idx)),
      .rd_data (child_rd)
   );

   // stack ram holds entries 0 .. sp-2, the top entry is in registers
   esa_ct_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (AW'(sp_ff - LEN_W'(1))),
      .wr_data ({top_idx_ff, top_lcp_ff}),
      .rd_addr (AW'(sp_below)),
      .rd_data (stack_rd)
   );

   // build sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      len_in        = len_ff;
      sp_in         = sp_ff;
      i_in          = i_ff;
      popped_in     = popped_ff;
      top_idx_in    = top_idx_ff;
      top_lcp_in    = top_lcp_ff;
      last_idx_in   = last_idx_ff;
      last_lcp_in   = last_lcp_ff;
      li_in         = li_ff;
      lcp_wr_en     = 1'b0;
      child_wr_en   = 1'b0;
      child_wr_idx  = top_idx_ff;
      child_wr_data = '0;
      stack_wr_en   = 1'b0;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_cvalid_in = 1'b0;
      rsp_status_in = STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_op == OP_WRITE) begin
                  if (wr_in_range) begin
                     lcp_wr_en = 1'b1;
                     if (req_last) begin
                        len_in   = LEN_W'(req_index) + LEN_W'(1);
                        i_in     = '0;
                        state_in = ST_CLEAR;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end else begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STATUS_RANGE;
                  end
               end else if (rd_in_range) begin
                  state_in = ST_READ;
               end else begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STATUS_RANGE;
               end
            end
         end

         ST_READ: begin
            rsp_load      = 1'b1;
            rsp_cvalid_in = child_rd.valid;
            rsp_value_in  = child_rd.valid ? child_rd.idx : '0;
            state_in      = ST_IDLE;
         end

         // empty out table entries 0 .. n-1
         ST_CLEAR: begin
            child_wr_en  = 1'b1;
            child_wr_idx = i_ff[IDX_W-1:0];
            if (i_ff == len_ff - LEN_W'(1)) begin
               sp_in      = LEN_W'(1);
               top_idx_in = '0;
               top_lcp_in = '0;
               i_in       = LEN_W'(1);
               phase_in   = PH_NEXT;
               popped_in  = 1'b0;
               state_in   = ST_LOAD;
            end else begin
               i_in = i_ff + LEN_W'(1);
            end
         end

         ST_LOAD: begin
            if (i_ff == len_ff) begin
               if (phase_ff == PH_NEXT) begin
                  // restart the stack for the up and down pass
                  sp_in      = LEN_W'(1);
                  top_idx_in = '0;
                  top_lcp_in = '0;
                  i_in       = LEN_W'(1);
                  phase_in   = PH_UPDOWN;
                  popped_in  = 1'b0;
               end else begin
                  // flush behaves as a pop loop against lcp zero
                  phase_in = PH_FLUSH;
                  li_in    = '0;
                  state_in = ST_TEST;
               end
            end else begin
               state_in = ST_LCMP;
            end
         end

         ST_LCMP: begin
            li_in    = lcp_rd;
            state_in = ST_TEST;
         end

         ST_TEST: begin
            if ((sp_ff > LEN_W'(1)) && (top_lcp_ff > li_ff)) begin
               // pop: stack ram read of the entry below is already addressed
               last_idx_in = top_idx_ff;
               last_lcp_in = top_lcp_ff;
               popped_in   = 1'b1;
               sp_in       = sp_ff - LEN_W'(1);
               state_in    = ST_POPW;
            end else begin
               case (phase_ff)
                  PH_NEXT: begin
                     if (top_lcp_ff == li_ff) begin
                        // next-l-index link, then i replaces the top
                        child_wr_en   = 1'b1;
                        child_wr_idx  = top_idx_ff;
                        child_wr_data = '{valid: 1'b1, idx: i_ff[IDX_W-1:0]};
                     end else begin
                        stack_wr_en = 1'b1;
                        sp_in       = sp_ff + LEN_W'(1);
                     end
                     top_idx_in = i_ff[IDX_W-1:0];
                     top_lcp_in = li_ff;
                     i_in       = i_ff + LEN_W'(1);
                     state_in   = ST_LOAD;
                  end
                  PH_UPDOWN: begin
                     if (popped_ff) begin
                        // up link at i-1
                        child_wr_en   = 1'b1;
                        child_wr_idx  = i_prev[IDX_W-1:0];
                        child_wr_data = '{valid: 1'b1, idx: last_idx_ff};
                     end
                     stack_wr_en = 1'b1;
                     sp_in       = sp_ff + LEN_W'(1);
                     top_idx_in  = i_ff[IDX_W-1:0];
                     top_lcp_in  = li_ff;
                     popped_in   = 1'b0;
                     i_in        = i_ff + LEN_W'(1);
                     state_in    = ST_LOAD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_POPW: begin
            top_idx_in = stack_rd_idx;
            top_lcp_in = stack_rd_lcp;
            state_in   = (phase_ff == PH_NEXT) ? ST_TEST : ST_CHK;
         end

         // down link into the entry below, if still empty
         ST_CHK: begin
            if (!child_rd.valid && (li_ff <= top_lcp_ff) && (last_lcp_ff != top_lcp_ff)) begin
               child_wr_en   = 1'b1;
               child_wr_idx  = top_idx_ff;
               child_wr_data = '{valid: 1'b1, idx: last_idx_ff};
            end
            state_in = ST_TEST;
         end

         ST_DONE: begin
            rsp_load      = 1'b1;
            rsp_status_in = STATUS_BUILT;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_NEXT;
         len_ff       <= '0;
         sp_ff        <= '0;
         i_ff         <= '0;
         popped_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         sp_ff     <= sp_in;
         i_ff      <= i_in;
         popped_ff <= popped_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      top_idx_ff  <= top_idx_in;
      top_lcp_ff  <= top_lcp_in;
      last_idx_ff <= last_idx_in;
      last_lcp_ff <= last_lcp_in;
      li_ff       <= li_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_cvalid_ff <= rsp_cvalid_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_child_value = rsp_value_ff;
   assign rsp_child_valid = rsp_cvalid_ff;
   assign rsp_status      = rsp_status_ff;

   // assertions
   a_stack_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) |-> (sp_ff >= LEN_W'(1)) && (sp_ff <= i_ff))
      else $error("stack count outside 1 .. scan position");

   a_table_write_range: assert property (@(posedge clock) disable iff (reset)
      child_wr_en |-> (LEN_W'(child_wr_idx) < len_ff))
      else $error("table write beyond array length");

   a_build_response: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid && (rsp_status == STATUS_BUILT))
      else $error("finished build gave no build response");

   a_read_response: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid && (rsp_status == STATUS_OK))
      else $error("table read gave no accepted response");

endmodule

// ----- tb/esa_child_table_builder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esa_child_table_builder_tb
// self-checking bench for the child table builder: loads lcp arrays of many
// lengths, with and without an end sentinel, triggers builds and reads the
// table back; a scoreboard class keeps its own lcp copy, rebuilds the table
// with the same stack passes and compares every response field by field
// ----------------------------------------------------------------------------
module esa_child_table_builder_tb;
   import esa_ct_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int CYCLE_LIMIT = 1000000;

   // one response as seen on the rsp_ ports
   typedef struct packed {
      logic [IDX_W-1:0] child_value;
      logic             child_valid;
      logic [1:0]       status;
   } child_reply_type;

   // -------------------------------------------------------------------------
   // scoreboard: mirror of lcp values and table, queue of awaited responses
   // -------------------------------------------------------------------------
   class child_table_scoreboard;
      logic [15:0]     lcp_mem [DEPTH];
      child_entry_type entry_mem [DEPTH];
      int              stack_mem [DEPTH];
      int              depth;
      int              length;
      child_reply_type awaited [$];
      int              errors;

      function new();
         foreach (lcp_mem[k]) lcp_mem[k] = '0;
         foreach (entry_mem[k]) entry_mem[k] = '0;
         depth  = 0;
         length = 0;
         errors = 0;
      endfunction

      // position 0 always counts as lcp zero, so the stack bottom stays put
      function logic [15:0] lcp_of(int k);
         return (k == 0 || k >= DEPTH) ? 16'd0 : lcp_mem[k];
      endfunction

      function void push_pos(int k);
         if (depth < DEPTH) begin
            stack_mem[depth] = k;
            depth++;
         end
      endfunction

      function int top_pos();
         return (depth == 0) ? 0 : stack_mem[depth-1];
      endfunction

      function void mark(int k, int target);
         if (k < DEPTH) entry_mem[k] = '{valid: 1'b1, idx: IDX_W'(target)};
      endfunction

      function void rebuild(int n);
         int          i;
         int          cut;
         int          under;
         bit          popped;
         logic [15:0] li;
         foreach (entry_mem[k]) entry_mem[k] = '0;

         // next-l-index links
         depth = 0;
         push_pos(0);
         for (i = 1; i < n; i++) begin
            li = lcp_of(i);
            while (depth > 1 && lcp_of(top_pos()) > li) depth--;
            if (lcp_of(top_pos()) == li) begin
               mark(top_pos(), i);
               depth = (depth > 1) ? depth - 1 : 0;
            end
            push_pos(i);
         end

         // down links, up links at i-1
         depth = 0;
         push_pos(0);
         for (i = 1; i < n; i++) begin
            li     = lcp_of(i);
            popped = 1'b0;
            cut    = 0;
            while (depth > 1 && lcp_of(top_pos()) > li) begin
               cut    = top_pos();
               popped = 1'b1;
               depth--;
               under  = top_pos();
               if (!entry_mem[under].valid && li <= lcp_of(under) &&
                   lcp_of(cut) != lcp_of(under))
                  mark(under, cut);
            end
            if (popped) mark(i - 1, cut);
            push_pos(i);
         end

         // close intervals still open when there is no end sentinel
         while (depth > 1 && lcp_of(top_pos()) > 16'd0) begin
            cut = top_pos();
            depth--;
            under = top_pos();
            if (!entry_mem[under].valid && lcp_of(cut) != lcp_of(under))
               mark(under, cut);
         end
      endfunction

      function void note_request(logic op, logic [IDX_W-1:0] idx, logic [15:0] val,
                                 logic last);
         child_reply_type r;
         int              pos;
         r   = '0;
         pos = idx;
         if (op == OP_WRITE) begin
            lcp_mem[pos] = val;
            if (last) begin
               length = pos + 1;
               rebuild(length);
               r.status = STATUS_BUILT;
            end else begin
               r.status = STATUS_OK;
            end
         end else if (length < 2 || pos >= length - 1) begin
            r.status = STATUS_RANGE;
         end else begin
            r.status = STATUS_OK;
            if (entry_mem[pos].valid) begin
               r.child_value = entry_mem[pos].idx;
               r.child_valid = 1'b1;
            end
         end
         awaited.insert(awaited.size(), r);
      endfunction

      function int pending_count();
         return awaited.size();
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [IDX_W-1:0] value, logic vld, logic [1:0] status);
         child_reply_type want;
         if (awaited.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
         if (vld !== want.child_valid)
            report_mismatch($sformatf("child_valid %b, expected %b", vld,
                                      want.child_valid));
         if (value !== want.child_value)
            report_mismatch($sformatf("child_value %0d, expected %0d", value,
                                      want.child_value));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, block ports
   // -------------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_WRITE;
   logic [IDX_W-1:0]  req_index = '0;
   logic [15:0]       req_lcp_value = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [IDX_W-1:0]  rsp_child_value;
   logic              rsp_child_valid;
   logic [1:0]        rsp_status;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   esa_child_table_builder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_index       (req_index),
      .req_lcp_value   (req_lcp_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_child_value (rsp_child_value),
      .rsp_child_valid (rsp_child_valid),
      .rsp_status      (rsp_status)
   );

   child_table_scoreboard board;

   // idle rates in percent per cycle, changed between phases
   int req_gap_pct = 0;
   int rsp_gap_pct = 0;

   int          sent_count = 0;   // accepted request transactions
   int          big_builds = 0;   // long builds are slow, keep them few
   bit          fill_done  = 1'b0;
   bit          lcp_written [DEPTH];
   int unsigned cycle_count = 0;

   // -------------------------------------------------------------------------
   // response side: random stall, every accepted transaction goes to the board
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_child_value, rsp_child_valid, rsp_status);
      rsp_stall <= (rsp_gap_pct != 0) && ($urandom_range(99) < rsp_gap_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------

   // optional idle cycles, then hold the transaction until it is taken
   task automatic send_req(logic op, logic [IDX_W-1:0] idx, logic [15:0] val,
                           logic last);
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_index     <= idx;
      req_lcp_value <= val;
      req_last      <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_request(op, idx, val, last);
      if (op == OP_WRITE) lcp_written[idx] = 1'b1;
      sent_count++;
   endtask

   // drop valid and hold off until every response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_count() != 0);
   endtask

   // small values give deep nesting and many equal lcps
   function automatic logic [15:0] lcp_pick();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 16'($urandom_range(3));
      if (r < 90) return 16'($urandom_range(10));
      return 16'($urandom);
   endfunction

   // a build over positions below p may only read written lcp entries
   function automatic bit prefix_written(int p);
      for (int k = 1; k < p; k++)
         if (!lcp_written[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 6) return 1;
      if (r < 80) return 2 + $urandom_range(14);
      if (r < 95 || !fill_done || big_builds >= 4) return 17 + $urandom_range(47);
      big_builds++;
      return 65 + $urandom_range(959);
   endfunction

   // short arrays are read front to back, long ones at random positions;
   // a few reads land past the table end
   task automatic read_back(int n);
      int count;
      int pos;
      count = (n + 2 < 40) ? n + 2 : 40;
      for (int k = 0; k < count; k++) begin
         if (n + 2 <= 40 && k < n) pos = k;
         else if ($urandom_range(99) < 75) pos = $urandom_range(n - 1);
         else pos = $urandom_range(DEPTH - 1);
         send_req(OP_READ, IDX_W'(pos), 16'($urandom), 1'($urandom));
      end
   endtask

   // load an array of length n in shuffled order, close it with last and read the
   // table; unless full is set, arrays whose prefix is already loaded only get touched up
   task automatic build_set(int n, bit full);
      int          order [$];
      int          j;
      int          tmp;
      logic [15:0] tail;
      if (n > 1) begin
         if (full || !prefix_written(n - 1)) begin
            for (int k = 0; k < n - 1; k++) order.insert(order.size(), k);
            for (int k = n - 2; k > 0; k--) begin
               j        = $urandom_range(k);
               tmp      = order[k];
               order[k] = order[j];
               order[j] = tmp;
            end
            foreach (order[k]) send_req(OP_WRITE, IDX_W'(order[k]), lcp_pick(), 1'b0);
         end else begin
            repeat ($urandom_range(8))
               send_req(OP_WRITE, IDX_W'($urandom_range(n - 2)), lcp_pick(), 1'b0);
         end
      end
      // a zero at the end acts as sentinel, anything else exercises the flush
      tail = ($urandom_range(99) < 60) ? 16'd0 : lcp_pick();
      send_req(OP_WRITE, IDX_W'(n - 1), tail, 1'b1);
      read_back(n);
   endtask

   // reads anywhere, writes anywhere without starting a build
   task automatic stray_item();
      if ($urandom_range(1))
         send_req(OP_READ, IDX_W'($urandom), 16'($urandom), 1'($urandom));
      else
         send_req(OP_WRITE, IDX_W'($urandom), lcp_pick(), 1'b0);
   endtask

   task automatic random_phase(int budget);
      int stop;
      int pick;
      int n;
      stop = sent_count + budget;
      while (sent_count < stop) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            build_set(pick_length(), 1'b0);
         end else if (pick < 84) begin
            repeat (1 + $urandom_range(3)) stray_item();
         end else if (pick < 94) begin
            // load started and abandoned, no last
            n = 2 + $urandom_range(20);
            for (int k = 0; k < n / 2; k++)
               send_req(OP_WRITE, IDX_W'(k), lcp_pick(), 1'b0);
         end else begin
            wait_for_drain();
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   logic [15:0] open_lcp [8] = '{16'hFFFF, 16'd2, 16'hFFFF, 16'h8000,
                                 16'd1, 16'd1, 16'd3, 16'd2};
   int          settle;

   initial begin
      board = new();
      foreach (lcp_written[k]) lcp_written[k] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles 31 percent, receiver 46 percent
      req_gap_pct = 31;
      rsp_gap_pct = 46;

      // reads before any build are out of range
      send_req(OP_READ, '0, 16'($urandom), 1'($urandom));
      send_req(OP_READ, '1, 16'($urandom), 1'($urandom));
      // length one gives an empty table
      send_req(OP_WRITE, '0, 16'h1234, 1'b1);
      send_req(OP_READ, '0, 16'($urandom), 1'($urandom));
      // length two; the value at position 0 does not matter
      send_req(OP_WRITE, '0, 16'hFFFF, 1'b0);
      send_req(OP_WRITE, IDX_W'(1), 16'd0, 1'b1);
      send_req(OP_READ, '0, 16'($urandom), 1'($urandom));
      send_req(OP_READ, IDX_W'(1), 16'($urandom), 1'($urandom));
      // top index, plain write
      send_req(OP_WRITE, '1, 16'd0, 1'b0);
      // no end sentinel, extreme lcp values, nested intervals
      for (int k = 0; k < 8; k++)
         send_req(OP_WRITE, IDX_W'(k), open_lcp[k], k == 7);
      for (int k = 0; k < 8; k++)
         send_req(OP_READ, IDX_W'(k), 16'($urandom), 1'($urandom));
      wait_for_drain();

      random_phase(110);

      // phase two: idle rates swapped, one full-length array up front
      req_gap_pct = 46;
      rsp_gap_pct = 31;
      build_set(DEPTH, 1'b1);
      fill_done = 1'b1;
      random_phase(100);

      // phase three: no idling
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      random_phase(100);

      // let the last responses come in, bounded by the longest build
      req_valid <= 1'b0;
      settle = 0;
      do begin
         @(posedge clock);
         settle++;
      end while (board.pending_count() != 0 && settle < 40000);
      repeat (20) @(posedge clock);
      if (board.pending_count() != 0)
         board.report_mismatch($sformatf("%0d transactions never answered",
                                         board.pending_count()));

      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/esa_ct_pkg.sv
hdl/esa_ct_ram.sv
hdl/esa_child_table_builder.sv
tb/esa_child_table_builder_tb.sv
